FILE: sv/cau_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_pkg
// Shared types, constants and helpers of the complex arithmetic unit.
// ----------------------------------------------------------------------------
package cau_pkg;

    localparam int DW = 32;
    localparam int FB = 16;
    localparam int PW = 2 * DW;
    localparam int SW = 2 * DW + 2;
    localparam int CW = 3 * DW + FB;
    localparam int RW = DW + 2;

    localparam logic signed [SW-1:0] SMAX = {{(SW-DW+1){1'b0}}, {(DW-1){1'b1}}};
    localparam logic signed [SW-1:0] SMIN = ~SMAX;
    localparam logic [DW-1:0]        DMAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic [DW-1:0]        DMIN = {1'b1, {(DW-1){1'b0}}};

    typedef enum logic [2:0] {
        ACT_ADD  = 3'd0,
        ACT_SUB  = 3'd1,
        ACT_MUL  = 3'd2,
        ACT_DIV  = 3'd3,
        ACT_CONJ = 3'd4,
        ACT_NEG  = 3'd5,
        ACT_MAG  = 3'd6,
        ACT_CMP  = 3'd7
    } t_action;

    typedef struct packed {
        logic          ovf;
        logic [DW-1:0] v;
    } t_sat;

    typedef struct packed {
        t_action       act;
        logic          dz;
        logic          ovf;
        logic          eq;
        logic          lt;
        logic          gt;
        logic [DW-1:0] s_re;
        logic [DW-1:0] s_im;
        logic          neg_re;
        logic          neg_im;
        logic          big_re;
        logic          big_im;
        logic [DW-1:0] n_re;
        logic [DW-1:0] n_im;
        logic [DW-1:0] q_re;
        logic [DW-1:0] q_im;
        logic [PW-1:0] r_re;
        logic [PW-1:0] r_im;
        logic [PW-1:0] den;
        logic [PW-1:0] sq_v;
        logic [RW-1:0] sq_rem;
        logic [DW-1:0] sq_root;
    } t_it;

    function automatic t_sat sat_fn(input logic signed [SW-1:0] v);
        t_sat r;
        r.ovf = 1'b0;
        r.v   = v[DW-1:0];
        if (v > SMAX) begin
            r.ovf = 1'b1;
            r.v   = SMAX[DW-1:0];
        end else if (v < SMIN) begin
            r.ovf = 1'b1;
            r.v   = SMIN[DW-1:0];
        end
        return r;
    endfunction

    function automatic t_sat div_fin(input logic [DW-1:0] q, input logic neg,
                                     input logic big);
        t_sat r;
        r.ovf = 1'b0;
        r.v   = q;
        if (big) begin
            r.ovf = 1'b1;
            r.v   = neg ? DMIN : DMAX;
        end else if (!neg) begin
            if (q[DW-1]) begin
                r.ovf = 1'b1;
                r.v   = DMAX;
            end
        end else if (q > DMIN) begin
            r.ovf = 1'b1;
            r.v   = DMIN;
        end else begin
            r.v = DW'(-q);
        end
        return r;
    endfunction

endpackage

FILE: sv/complex_arithmetic_unit_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// complex_arithmetic_unit_top
// Pipelined complex ALU on signed fixed-point operands.
//
//   Channel  Handshake          Word
//   input    i_valid / o_ready  i_action, i_a_re, i_a_im, i_b_re, i_b_im
//   output   o_valid / i_ready  o_res_re, o_res_im, flags
//
// One word enters per cycle while the output is not stalled. Its stages are the
// product, sum and setup stages, one stage per quotient and root bit,
// and the output register. Synchronous active-low reset clears all valid
// bits. A stall at the output holds every stage in place.
// ----------------------------------------------------------------------------
module complex_arithmetic_unit_top
    import cau_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [2:0]           i_action,
    input  logic signed [DW-1:0] i_a_re,
    input  logic signed [DW-1:0] i_a_im,
    input  logic signed [DW-1:0] i_b_re,
    input  logic signed [DW-1:0] i_b_im,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic signed [DW-1:0] o_res_re,
    output logic signed [DW-1:0] o_res_im,
    output logic                 o_equal,
    output logic                 o_mag_less,
    output logic                 o_mag_greater,
    output logic                 o_div_by_zero,
    output logic                 o_overflow
);

    logic en;

    logic                 r_a_vld;
    t_action              r_a_act;
    logic signed [DW-1:0] r_a_ar, r_a_ai, r_a_br, r_a_bi;
    logic signed [PW-1:0] r_p_arbr, r_p_aibi, r_p_arbi, r_p_aibr;
    logic signed [PW-1:0] r_p_arar, r_p_aiai, r_p_brbr, r_p_bibi;

    logic                 r_b_vld;
    t_action              r_b_act;
    logic signed [DW-1:0] r_b_ar, r_b_ai, r_b_br, r_b_bi;
    logic signed [SW-1:0] r_mul_re, r_mul_im, r_num_re, r_num_im;
    logic [PW-1:0]        r_mag_a, r_mag_b, r_den;

    logic [DW:0] r_vld;
    t_it         r_it [DW+1];
    t_it         w_it [DW];
    t_it         n_it;

    logic                 r_o_vld;
    logic signed [DW-1:0] r_res_re, r_res_im;
    logic                 r_eq, r_lt, r_gt, r_dz, r_ovf;

    assign en      = !r_o_vld || i_ready;
    assign o_ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_vld   <= '0;
            r_o_vld <= 1'b0;
        end else if (en) begin
            r_a_vld <= i_valid;
            r_b_vld <= r_a_vld;
            r_vld   <= {r_vld[DW-1:0], r_b_vld};
            r_o_vld <= r_vld[DW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_act  <= t_action'(i_action);
            r_a_ar   <= i_a_re;
            r_a_ai   <= i_a_im;
            r_a_br   <= i_b_re;
            r_a_bi   <= i_b_im;
            r_p_arbr <= i_a_re * i_b_re;
            r_p_aibi <= i_a_im * i_b_im;
            r_p_arbi <= i_a_re * i_b_im;
            r_p_aibr <= i_a_im * i_b_re;
            r_p_arar <= i_a_re * i_a_re;
            r_p_aiai <= i_a_im * i_a_im;
            r_p_brbr <= i_b_re * i_b_re;
            r_p_bibi <= i_b_im * i_b_im;

            r_b_act  <= r_a_act;
            r_b_ar   <= r_a_ar;
            r_b_ai   <= r_a_ai;
            r_b_br   <= r_a_br;
            r_b_bi   <= r_a_bi;
            r_mul_re <= SW'(r_p_arbr) - SW'(r_p_aibi);
            r_mul_im <= SW'(r_p_arbi) + SW'(r_p_aibr);
            r_num_re <= SW'(r_p_arbr) + SW'(r_p_aibi);
            r_num_im <= SW'(r_p_aibr) - SW'(r_p_arbi);
            r_mag_a  <= $unsigned(r_p_arar) + $unsigned(r_p_aiai);
            r_mag_b  <= $unsigned(r_p_brbr) + $unsigned(r_p_bibi);
            r_den    <= $unsigned(r_p_brbr) + $unsigned(r_p_bibi);
        end
    end

    // setup of dividers, root and the single-stage operations
    always_comb begin
        logic [SW-1:0] ab_re, ab_im;
        logic [CW-1:0] nx_re, nx_im, dx, sh_re, sh_im;
        t_sat          sa, sb;
        n_it         = '0;
        n_it.act     = r_b_act;
        ab_re        = r_num_re[SW-1] ? SW'(-r_num_re) : r_num_re;
        ab_im        = r_num_im[SW-1] ? SW'(-r_num_im) : r_num_im;
        nx_re        = {{DW{1'b0}}, ab_re[PW-1:0], {FB{1'b0}}};
        nx_im        = {{DW{1'b0}}, ab_im[PW-1:0], {FB{1'b0}}};
        dx           = {{FB{1'b0}}, r_den, {DW{1'b0}}};
        sh_re        = nx_re >> DW;
        sh_im        = nx_im >> DW;
        n_it.neg_re  = r_num_re[SW-1];
        n_it.neg_im  = r_num_im[SW-1];
        n_it.big_re  = nx_re >= dx;
        n_it.big_im  = nx_im >= dx;
        n_it.n_re    = nx_re[DW-1:0];
        n_it.n_im    = nx_im[DW-1:0];
        n_it.r_re    = sh_re[PW-1:0];
        n_it.r_im    = sh_im[PW-1:0];
        n_it.den     = r_den;
        n_it.sq_v    = r_mag_a;
        n_it.dz      = (r_b_act == ACT_DIV) && (r_den == '0);
        n_it.eq      = (r_b_act == ACT_CMP) && (r_b_ar == r_b_br) && (r_b_ai == r_b_bi);
        n_it.lt      = (r_b_act == ACT_CMP) && (r_mag_a < r_mag_b);
        n_it.gt      = (r_b_act == ACT_CMP) && (r_mag_a > r_mag_b);
        sa           = '0;
        sb           = '0;
        unique case (r_b_act)
            ACT_ADD: begin
                sa = sat_fn(SW'(r_b_ar) + SW'(r_b_br));
                sb = sat_fn(SW'(r_b_ai) + SW'(r_b_bi));
            end
            ACT_SUB: begin
                sa = sat_fn(SW'(r_b_ar) - SW'(r_b_br));
                sb = sat_fn(SW'(r_b_ai) - SW'(r_b_bi));
            end
            ACT_MUL: begin
                sa = sat_fn(r_mul_re >>> FB);
                sb = sat_fn(r_mul_im >>> FB);
            end
            ACT_CONJ: begin
                sa = sat_fn(SW'(r_b_ar));
                sb = sat_fn(-SW'(r_b_ai));
            end
            ACT_NEG: begin
                sa = sat_fn(-SW'(r_b_ar));
                sb = sat_fn(-SW'(r_b_ai));
            end
            default: begin
                sa = '0;
                sb = '0;
            end
        endcase
        n_it.s_re = sa.v;
        n_it.s_im = sb.v;
        n_it.ovf  = sa.ovf | sb.ovf;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_it[0] <= n_it;
        end
    end

    for (genvar k = 0; k < DW; k++) begin : g_step
        cau_step u_step (
            .i_it (r_it[k]),
            .o_it (w_it[k])
        );

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_it[k+1] <= w_it[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        t_it  f;
        t_sat dr, di;
        f  = r_it[DW];
        dr = div_fin(f.q_re, f.neg_re, f.big_re);
        di = div_fin(f.q_im, f.neg_im, f.big_im);
        if (en) begin
            r_eq <= f.eq;
            r_lt <= f.lt;
            r_gt <= f.gt;
            r_dz <= f.dz;
            unique case (f.act)
                ACT_DIV: begin
                    if (f.dz) begin
                        r_res_re <= '0;
                        r_res_im <= '0;
                        r_ovf    <= 1'b0;
                    end else begin
                        r_res_re <= dr.v;
                        r_res_im <= di.v;
                        r_ovf    <= dr.ovf | di.ovf;
                    end
                end
                ACT_MAG: begin
                    r_res_re <= f.sq_root[DW-1] ? DMAX : f.sq_root;
                    r_res_im <= '0;
                    r_ovf    <= f.sq_root[DW-1];
                end
                ACT_CMP: begin
                    r_res_re <= '0;
                    r_res_im <= '0;
                    r_ovf    <= 1'b0;
                end
                default: begin
                    r_res_re <= f.s_re;
                    r_res_im <= f.s_im;
                    r_ovf    <= f.ovf;
                end
            endcase
        end
    end

    assign o_valid       = r_o_vld;
    assign o_res_re      = r_res_re;
    assign o_res_im      = r_res_im;
    assign o_equal       = r_eq;
    assign o_mag_less    = r_lt;
    assign o_mag_greater = r_gt;
    assign o_div_by_zero = r_dz;
    assign o_overflow    = r_ovf;

endmodule

FILE: sv/cau_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_step
// One digit of both restoring dividers and of the integer square root.
// ----------------------------------------------------------------------------
module cau_step
    import cau_pkg::*;
(
    input  t_it i_it,
    output t_it o_it
);

    logic [PW:0]   d_re;
    logic [PW:0]   d_im;
    logic [PW:0]   d_den;
    logic [RW+1:0] s_t;
    logic [RW+1:0] s_trial;

    always_comb begin
        o_it    = i_it;
        d_den   = {1'b0, i_it.den};
        d_re    = {i_it.r_re, i_it.n_re[DW-1]};
        d_im    = {i_it.r_im, i_it.n_im[DW-1]};
        s_t     = {i_it.sq_rem, i_it.sq_v[PW-1:PW-2]};
        s_trial = {2'b00, i_it.sq_root, 2'b01};

        o_it.n_re = i_it.n_re << 1;
        o_it.n_im = i_it.n_im << 1;
        if (d_re >= d_den) begin
            o_it.r_re = PW'(d_re - d_den);
            o_it.q_re = {i_it.q_re[DW-2:0], 1'b1};
        end else begin
            o_it.r_re = d_re[PW-1:0];
            o_it.q_re = {i_it.q_re[DW-2:0], 1'b0};
        end
        if (d_im >= d_den) begin
            o_it.r_im = PW'(d_im - d_den);
            o_it.q_im = {i_it.q_im[DW-2:0], 1'b1};
        end else begin
            o_it.r_im = d_im[PW-1:0];
            o_it.q_im = {i_it.q_im[DW-2:0], 1'b0};
        end

        o_it.sq_v = i_it.sq_v << 2;
        if (s_t >= s_trial) begin
            o_it.sq_rem  = RW'(s_t - s_trial);
            o_it.sq_root = {i_it.sq_root[DW-2:0], 1'b1};
        end else begin
            o_it.sq_rem  = s_t[RW-1:0];
            o_it.sq_root = {i_it.sq_root[DW-2:0], 1'b0};
        end
    end

endmodule

FILE: sv/cau_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_checker
// Port-level checks of the complex arithmetic unit, bound to the top level.
// ----------------------------------------------------------------------------
module cau_checker
    import cau_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_valid,
    input logic                 o_ready,
    input logic [2:0]           i_action,
    input logic signed [DW-1:0] i_a_re,
    input logic signed [DW-1:0] i_a_im,
    input logic signed [DW-1:0] i_b_re,
    input logic signed [DW-1:0] i_b_im,
    input logic                 o_valid,
    input logic                 i_ready,
    input logic signed [DW-1:0] o_res_re,
    input logic signed [DW-1:0] o_res_im,
    input logic                 o_equal,
    input logic                 o_mag_less,
    input logic                 o_mag_greater,
    input logic                 o_div_by_zero,
    input logic                 o_overflow
);

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_ready |=> i_valid && $stable(i_action)
            && $stable(i_a_re) && $stable(i_a_im)
            && $stable(i_b_re) && $stable(i_b_im))
        else $error("input word changed while stalled");

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("output word dropped while stalled");

    a_mag_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_mag_less && o_mag_greater))
        else $error("magnitude both less and greater");

    a_dz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_div_by_zero |-> o_res_re == '0 && o_res_im == '0 && !o_overflow)
        else $error("zero divisor word not cleared");

    a_eq_mag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_equal |-> !o_mag_less && !o_mag_greater)
        else $error("equal operands with unequal magnitude");

endmodule

bind complex_arithmetic_unit_top cau_checker u_cau_checker (.*);
